// ===== rtl/sfcd_pkg.sv =====
// Shared constants and the CRC-16 byte update for the sensor frame decoder.
package sfcd_pkg;

    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] SIGN_BIT = 16'h8000;
    localparam logic [15:0] MAG_MASK = 16'h7FFF;

    // Byte positions inside the frame
    localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_HUM_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_HUM_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_TMP_HI = IDX_W'(4);
    localparam logic [IDX_W-1:0] IDX_TMP_LO = IDX_W'(5);
    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_BYTES - 1);

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== rtl/sensor_frame_crc_decoder.sv =====
// Top level: byte-wise frame checker and decoder for a humidity/temperature sensor.
//
// Usage
//   Input channel (in_valid/in_ready) carries one frame byte per transfer in
//   rx_byte; frame_start marks byte 0 and resynchronises the frame at any point,
//   dropping a partial frame without a result. Without a start mark the byte
//   position simply advances and wraps after byte 7.
//   Output channel (out_valid/out_ready) carries one result per frame, built on
//   byte 7: humidity_raw (bytes 2,3), temperature (sign-magnitude bytes 4,5
//   turned into two's complement) and crc_ok (CRC-16 over bytes 0..5 against
//   the little-endian word in bytes 6,7).
//   Timing: a byte goes into the input register at its transfer and is folded
//   into the frame state from there; on byte 7 the result register and out_valid
//   are loaded at the same edge as the frame state.
//   Throughput: one byte per cycle while no byte 7 waits on a full result register;
//   the unrolled CRC byte update is combinational between input and state registers.
//   Stall: while a result waits in the output register, bytes 0..6 of the
//   next frame keep flowing; only a byte 7 holds in the input register until
//   the result is taken, and in_ready drops only when that held byte is stuck.
//   Reset: asynchronous, active low; clears both valid flags and the hold registers,
//   returns the byte position to 0 and the CRC to 0xFFFF; byte and result data are not reset.
module sensor_frame_crc_decoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        humidity_raw,
    output logic signed [15:0] temperature,
    output logic               crc_ok
);

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;

    // Frame state
    logic [sfcd_pkg::IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]                crc_reg, crc_next;
    logic [15:0]                humidity_hold_reg, humidity_hold_next;
    logic [15:0]                temperature_hold_reg, temperature_hold_next;
    logic [7:0]                 crc_low_hold_reg, crc_low_hold_next;

    // Result register
    logic               out_valid_reg;
    logic [15:0]        humidity_raw_reg;
    logic signed [15:0] temperature_reg;
    logic               crc_ok_reg;

    // Stage 1 decode
    logic [sfcd_pkg::IDX_W-1:0] idx;
    logic [15:0]                crc_base;
    logic                       s1_last;
    logic                       s1_go;
    logic [15:0]                temp_mag;
    logic signed [15:0]         temp_conv;
    logic [15:0]                crc_received;

    // A start mark forces byte 0 and a fresh CRC
    assign idx      = s1_start_reg ? sfcd_pkg::IDX_FIRST : byte_index_reg;
    assign crc_base = s1_start_reg ? sfcd_pkg::CRC_INIT  : crc_reg;
    assign s1_last  = (idx == sfcd_pkg::IDX_CRC_HI);

    // Only the closing byte needs room in the result register
    assign s1_go    = s1_valid_reg && (!s1_last || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    // Sign-magnitude to two's complement; negative zero folds to zero
    assign temp_mag     = temperature_hold_reg & sfcd_pkg::MAG_MASK;
    assign temp_conv    = ((temperature_hold_reg & sfcd_pkg::SIGN_BIT) != 16'h0000)
                          ? $signed(16'(16'h0000 - temp_mag)) : $signed(temp_mag);
    assign crc_received = {s1_byte_reg, crc_low_hold_reg};

    always_comb
    begin
        byte_index_next       = byte_index_reg;
        crc_next              = crc_reg;
        humidity_hold_next    = humidity_hold_reg;
        temperature_hold_next = temperature_hold_reg;
        crc_low_hold_next     = crc_low_hold_reg;
        if (s1_go)
        begin
            // CRC covers every byte ahead of the received CRC
            if (idx < sfcd_pkg::IDX_CRC_LO)
                crc_next = sfcd_pkg::crc_add_byte(crc_base, s1_byte_reg);
            else
                crc_next = crc_base;

            unique case (idx)
                sfcd_pkg::IDX_HUM_HI: humidity_hold_next    = {s1_byte_reg, humidity_hold_reg[7:0]};
                sfcd_pkg::IDX_HUM_LO: humidity_hold_next    = {humidity_hold_reg[15:8], s1_byte_reg};
                sfcd_pkg::IDX_TMP_HI: temperature_hold_next = {s1_byte_reg, temperature_hold_reg[7:0]};
                sfcd_pkg::IDX_TMP_LO: temperature_hold_next = {temperature_hold_reg[15:8], s1_byte_reg};
                sfcd_pkg::IDX_CRC_LO: crc_low_hold_next     = s1_byte_reg;
                default:              ;
            endcase

            if (s1_last)
            begin
                // Close the frame and rearm for the next one
                byte_index_next = sfcd_pkg::IDX_FIRST;
                crc_next        = sfcd_pkg::CRC_INIT;
            end
            else
            begin
                byte_index_next = idx + 1'b1;
            end
        end
    end

    // Input register: load on transfer, drop once consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg       <= sfcd_pkg::IDX_FIRST;
            crc_reg              <= sfcd_pkg::CRC_INIT;
            humidity_hold_reg    <= 16'h0000;
            temperature_hold_reg <= 16'h0000;
            crc_low_hold_reg     <= 8'h00;
        end
        else
        begin
            byte_index_reg       <= byte_index_next;
            crc_reg              <= crc_next;
            humidity_hold_reg    <= humidity_hold_next;
            temperature_hold_reg <= temperature_hold_next;
            crc_low_hold_reg     <= crc_low_hold_next;
        end
    end

    // Result register: hold until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last)
        begin
            humidity_raw_reg <= humidity_hold_reg;
            temperature_reg  <= temp_conv;
            crc_ok_reg       <= (crc_reg == crc_received);
        end
    end

    assign out_valid    = out_valid_reg;
    assign humidity_raw = humidity_raw_reg;
    assign temperature  = temperature_reg;
    assign crc_ok       = crc_ok_reg;

    // An empty input register always takes a byte
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("in_ready low with empty input register");

    // Closing a frame rearms position and CRC
    a_frame_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last) |=>
            (byte_index_reg == sfcd_pkg::IDX_FIRST) && (crc_reg == sfcd_pkg::CRC_INIT))
        else $error("frame state not rearmed after byte 7");

    // A start-marked byte leaves the position at byte 1
    a_start_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_start_reg) |=> (byte_index_reg == sfcd_pkg::IDX_W'(1)))
        else $error("start mark did not resynchronise the frame");

    // Negative zero never reaches the output
    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (temperature_reg != 16'sh8000))
        else $error("temperature shows negative zero");

    // A waiting result is not overwritten by a new frame
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(s1_go && s1_last))
        else $error("result register overwritten while stalled");

endmodule
